### hw/rtl/jts_pkg.sv
package jts_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_NEUTRAL_PULSE    = 3'd0,
    CFG_STEER_DEADZONE   = 3'd1,
    CFG_DRIVE_DEADZONE   = 3'd2,
    CFG_STEER_GAIN       = 3'd3,
    CFG_DRIVE_SCALE      = 3'd4,
    CFG_ESTOP_HOLD_TICKS = 3'd5,
    CFG_SEND_DIVIDER     = 3'd6
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Reset values of the configuration registers
  localparam logic [11:0] RST_NEUTRAL_PULSE    = 12'd1500;
  localparam logic [14:0] RST_STEER_DEADZONE   = 15'd6554;
  localparam logic [14:0] RST_DRIVE_DEADZONE   = 15'd9830;
  localparam logic [10:0] RST_STEER_GAIN       = 11'd500;
  localparam logic [15:0] RST_DRIVE_SCALE      = 16'd36571;
  localparam logic [15:0] RST_ESTOP_HOLD_TICKS = 16'd100;
  localparam logic [7:0]  RST_SEND_DIVIDER     = 8'd10;

  typedef struct packed {
    logic [11:0] neutral_pulse;
    logic [14:0] steer_deadzone;
    logic [14:0] drive_deadzone;
    logic [10:0] steer_gain;
    logic [15:0] drive_scale;
    logic [15:0] estop_hold_ticks;
    logic [7:0]  send_divider;
  } jts_cfg_t;

  typedef struct packed {
    logic signed [15:0] axis_steer;
    logic signed [15:0] axis_drive;
    logic               estop_button;
    logic               halt;
  } jts_item_t;

  typedef struct packed {
    logic [11:0] steer_cmd;
    logic [11:0] drive_cmd;
    logic        send_strobe;
  } jts_result_t;

  typedef struct packed {
    logic [15:0] estop_remaining;
    logic [7:0]  divider_phase;
  } jts_state_t;

endpackage

### hw/rtl/jts_map.sv
module jts_map
  import jts_pkg::*;
(
  input  jts_item_t   item,
  input  jts_cfg_t    cfg,
  input  jts_state_t  state,
  output jts_result_t result,
  output jts_state_t  state_nxt
);

  logic               active;
  logic signed [16:0] ax_s;
  logic [16:0]        mag_s;
  logic signed [28:0] steer_prod;
  logic signed [14:0] steer_sum;
  logic signed [16:0] a_d;
  logic [16:0]        mag_d;
  logic signed [16:0] adj_d;
  logic signed [33:0] drive_prod;
  logic signed [14:0] drive_sum;
  logic [11:0]        steer_sat;
  logic [11:0]        drive_sat;
  logic [7:0]         div_eff;
  logic [8:0]         phase_inc;

  // Saturate a signed sum to 0..4095
  function automatic logic [11:0] sat12(input logic signed [14:0] v);
    if (v[14]) begin
      return 12'd0;
    end else if (v[13:12] != 2'b00) begin
      return 12'hFFF;
    end
    return v[11:0];
  endfunction

  // Steering: floor(axis * gain / 2^15) is the upper part of the product
  assign ax_s       = {item.axis_steer[15], item.axis_steer};
  assign mag_s      = ax_s[16] ? 17'(-ax_s) : 17'(ax_s);
  assign steer_prod = ax_s * $signed({1'b0, cfg.steer_gain});
  assign steer_sum  = $signed({3'b000, cfg.neutral_pulse})
                    + $signed({steer_prod[28], steer_prod[28:15]});

  // Drive: negated axis moved toward zero by the deadzone, Q8.8 scale
  assign a_d        = -$signed({item.axis_drive[15], item.axis_drive});
  assign mag_d      = a_d[16] ? 17'(-a_d) : 17'(a_d);
  assign adj_d      = a_d[16] ? a_d + $signed({2'b00, cfg.drive_deadzone})
                              : a_d - $signed({2'b00, cfg.drive_deadzone});
  assign drive_prod = adj_d * $signed({1'b0, cfg.drive_scale});
  assign drive_sum  = $signed({3'b000, cfg.neutral_pulse})
                    + $signed({{4{drive_prod[33]}}, drive_prod[33:23]});

  assign steer_sat = sat12(steer_sum);
  assign drive_sat = sat12(drive_sum);

  assign div_eff   = (cfg.send_divider == 8'd0) ? 8'd1 : cfg.send_divider;
  assign phase_inc = {1'b0, state.divider_phase} + 9'd1;

  // E-stop hold, strobe phase and output selection
  always_comb begin
    state_nxt = state;
    active    = 1'b0;
    result.steer_cmd   = cfg.neutral_pulse;
    result.drive_cmd   = cfg.neutral_pulse;
    result.send_strobe = 1'b1;
    if (!item.halt) begin
      if (item.estop_button) begin
        state_nxt.estop_remaining = cfg.estop_hold_ticks;
      end else if (state.estop_remaining != 16'd0) begin
        state_nxt.estop_remaining = state.estop_remaining - 16'd1;
      end else begin
        active = 1'b1;
      end

      if (active && (mag_s > {2'b00, cfg.steer_deadzone})) begin
        result.steer_cmd = steer_sat;
      end
      if (active && (mag_d > {2'b00, cfg.drive_deadzone})) begin
        result.drive_cmd = drive_sat;
      end

      result.send_strobe = (state.divider_phase == 8'd0);
      if (phase_inc >= {1'b0, div_eff}) begin
        state_nxt.divider_phase = 8'd0;
      end else begin
        state_nxt.divider_phase = phase_inc[7:0];
      end
    end
  end

endmodule

### hw/rtl/joystick_to_servo_command.sv
// Joystick to servo command mapper.
//
// Input channel (in_valid/in_ready) carries one tick: two Q1.15 stick axes,
// the e-stop button and the halt flag. Output channel (out_valid/out_ready)
// returns one result per tick: steering and drive commands (0..4095) and
// the send strobe. The user writes configuration via cfg_we/cfg_index/
// cfg_wdata, one register per cycle, while no tick is in flight, unchecked.
//
// Datapath: one input register, then the mapping logic (two small
// multipliers, add, saturate) into the output register. Throughput is one
// tick per cycle while out_ready stays high.
//
// Reset (synchronous, rst_n low) empties both stages, clears the e-stop
// hold counter and the strobe phase, and loads the register defaults.
// When the receiver stalls, the output register holds its result and the
// input register keeps one more tick; in_ready drops only when both are
// full and out_ready is low.
module joystick_to_servo_command
  import jts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    in_axis_steer,
  input  logic signed [15:0]    in_axis_drive,
  input  logic                  in_estop_button,
  input  logic                  in_halt,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [11:0]           out_steer_cmd,
  output logic [11:0]           out_drive_cmd,
  output logic                  out_send_strobe,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  jts_cfg_t    cfg_r;
  jts_state_t  state_r;
  jts_state_t  state_nxt;
  jts_item_t   s1_item_r;
  logic        s1_valid_r;
  jts_result_t out_res_r;
  jts_result_t res_nxt;
  logic        out_valid_r;
  logic        out_free;
  logic        s1_fire;

  // Pipeline handshake
  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  jts_map u_map (
    .item      (s1_item_r),
    .cfg       (cfg_r),
    .state     (state_r),
    .result    (res_nxt),
    .state_nxt (state_nxt)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.neutral_pulse    <= RST_NEUTRAL_PULSE;
      cfg_r.steer_deadzone   <= RST_STEER_DEADZONE;
      cfg_r.drive_deadzone   <= RST_DRIVE_DEADZONE;
      cfg_r.steer_gain       <= RST_STEER_GAIN;
      cfg_r.drive_scale      <= RST_DRIVE_SCALE;
      cfg_r.estop_hold_ticks <= RST_ESTOP_HOLD_TICKS;
      cfg_r.send_divider     <= RST_SEND_DIVIDER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NEUTRAL_PULSE:    cfg_r.neutral_pulse    <= cfg_wdata[11:0];
        CFG_STEER_DEADZONE:   cfg_r.steer_deadzone   <= cfg_wdata[14:0];
        CFG_DRIVE_DEADZONE:   cfg_r.drive_deadzone   <= cfg_wdata[14:0];
        CFG_STEER_GAIN:       cfg_r.steer_gain       <= cfg_wdata[10:0];
        CFG_DRIVE_SCALE:      cfg_r.drive_scale      <= cfg_wdata;
        CFG_ESTOP_HOLD_TICKS: cfg_r.estop_hold_ticks <= cfg_wdata;
        CFG_SEND_DIVIDER:     cfg_r.send_divider     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Input stage and tick state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      state_r    <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.axis_steer   <= in_axis_steer;
      s1_item_r.axis_drive   <= in_axis_drive;
      s1_item_r.estop_button <= in_estop_button;
      s1_item_r.halt         <= in_halt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_steer_cmd   = out_res_r.steer_cmd;
  assign out_drive_cmd   = out_res_r.drive_cmd;
  assign out_send_strobe = out_res_r.send_strobe;

endmodule

### hw/rtl/jts_checker.sv
module jts_checker
  import jts_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic signed [15:0]    in_axis_steer,
  input logic signed [15:0]    in_axis_drive,
  input logic                  in_estop_button,
  input logic                  in_halt,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [11:0]           out_steer_cmd,
  input logic [11:0]           out_drive_cmd,
  input logic                  out_send_strobe
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_steer_cmd)
      && $stable(out_drive_cmd) && $stable(out_send_strobe))
    else $error("stalled result changed");

  // A waiting input tick holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_axis_steer)
      && $stable(in_axis_drive) && $stable(in_estop_button) && $stable(in_halt))
    else $error("waiting input tick changed");

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Input backpressure only comes from a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // A halt tick comes out with a strobe and equal commands once the output stage is free
  a_halt_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_halt ##1 (!out_valid || out_ready)
      |=> out_valid && out_send_strobe && (out_steer_cmd == out_drive_cmd))
    else $error("halt tick result wrong");

endmodule

bind joystick_to_servo_command jts_checker u_jts_checker (.*);

### verif/jts_tick_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the joystick mapper, predicts every tick from its
// own copy of the registers and state, and compares each result transfer.
module jts_tick_checker
  import jts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic signed [15:0]    in_axis_steer,
  input  logic signed [15:0]    in_axis_drive,
  input  logic                  in_estop_button,
  input  logic                  in_halt,

  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [11:0]           out_steer_cmd,
  input  logic [11:0]           out_drive_cmd,
  input  logic                  out_send_strobe,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,

  output int                    n_fail,
  output int                    n_pending
);

  localparam int SHOW_LIMIT = 10;

  jts_cfg_t      regs;
  logic [15:0]   hold_left;
  logic [7:0]    strobe_phase;
  jts_result_t   cmd_q[$];
  int            fail_cnt;

  function automatic logic [11:0] clamp12(input longint v);
    if (v < 0) return 12'd0;
    if (v > 4095) return 12'd4095;
    return v[11:0];
  endfunction

  // One tick of the mapper; outside a halt it updates the hold counter and strobe phase
  function automatic jts_result_t map_tick(input jts_item_t t);
    longint      neutral;
    longint      ax_s;
    longint      ax_d;
    longint      mag_s;
    longint      mag_d;
    longint      adj;
    longint      steer;
    longint      drive;
    logic        active;
    logic [7:0]  div;
    jts_result_t r;
    neutral = longint'(regs.neutral_pulse);
    ax_s    = longint'($signed(t.axis_steer));
    ax_d    = -longint'($signed(t.axis_drive));
    steer   = neutral;
    drive   = neutral;
    active  = 1'b0;

    // halt: neutral with a strobe, state untouched
    if (t.halt) begin
      r.steer_cmd   = clamp12(neutral);
      r.drive_cmd   = clamp12(neutral);
      r.send_strobe = 1'b1;
      return r;
    end

    // e-stop hold
    if (t.estop_button) begin
      hold_left = regs.estop_hold_ticks;
    end else if (hold_left != 16'd0) begin
      hold_left = hold_left - 16'd1;
    end else begin
      active = 1'b1;
    end

    if (active) begin
      mag_s = (ax_s < 0) ? -ax_s : ax_s;
      mag_d = (ax_d < 0) ? -ax_d : ax_d;
      if (mag_s > longint'(regs.steer_deadzone)) begin
        steer = neutral + ((ax_s * longint'(regs.steer_gain)) >>> 15);
      end
      if (mag_d > longint'(regs.drive_deadzone)) begin
        adj   = (ax_d < 0) ? ax_d + longint'(regs.drive_deadzone)
                           : ax_d - longint'(regs.drive_deadzone);
        drive = neutral + ((adj * longint'(regs.drive_scale)) >>> 23);
      end
    end

    r.steer_cmd   = clamp12(steer);
    r.drive_cmd   = clamp12(drive);
    r.send_strobe = (strobe_phase == 8'd0);

    // strobe phase; a zero divider counts as one
    div = (regs.send_divider == 8'd0) ? 8'd1 : regs.send_divider;
    if ({1'b0, strobe_phase} + 9'd1 >= {1'b0, div}) begin
      strobe_phase = 8'd0;
    end else begin
      strobe_phase = strobe_phase + 8'd1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    jts_item_t   tick;
    jts_result_t want;
    jts_result_t got;
    if (!rst_n) begin
      regs.neutral_pulse    = RST_NEUTRAL_PULSE;
      regs.steer_deadzone   = RST_STEER_DEADZONE;
      regs.drive_deadzone   = RST_DRIVE_DEADZONE;
      regs.steer_gain       = RST_STEER_GAIN;
      regs.drive_scale      = RST_DRIVE_SCALE;
      regs.estop_hold_ticks = RST_ESTOP_HOLD_TICKS;
      regs.send_divider     = RST_SEND_DIVIDER;
      hold_left             = 16'd0;
      strobe_phase          = 8'd0;
      cmd_q.delete();
      fail_cnt              = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_NEUTRAL_PULSE:    regs.neutral_pulse    = cfg_wdata[11:0];
          CFG_STEER_DEADZONE:   regs.steer_deadzone   = cfg_wdata[14:0];
          CFG_DRIVE_DEADZONE:   regs.drive_deadzone   = cfg_wdata[14:0];
          CFG_STEER_GAIN:       regs.steer_gain       = cfg_wdata[10:0];
          CFG_DRIVE_SCALE:      regs.drive_scale      = cfg_wdata[15:0];
          CFG_ESTOP_HOLD_TICKS: regs.estop_hold_ticks = cfg_wdata[15:0];
          CFG_SEND_DIVIDER:     regs.send_divider     = cfg_wdata[7:0];
          default: ;
        endcase
      end

      // result transfer
      if (out_valid && out_ready) begin
        got.steer_cmd   = out_steer_cmd;
        got.drive_cmd   = out_drive_cmd;
        got.send_strobe = out_send_strobe;
        if (cmd_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= SHOW_LIMIT) begin
            $display("%0t: unexpected result steer %0d drive %0d strobe %0b",
                     $realtime, got.steer_cmd, got.drive_cmd, got.send_strobe);
          end
        end else begin
          want = cmd_q.pop_front();
          if (got.steer_cmd !== want.steer_cmd || got.drive_cmd !== want.drive_cmd ||
              got.send_strobe !== want.send_strobe) begin
            fail_cnt++;
            if (fail_cnt <= SHOW_LIMIT) begin
              $display("%0t: mismatch steer exp %0d got %0d, drive exp %0d got %0d, %s",
                       $realtime, want.steer_cmd, got.steer_cmd,
                       want.drive_cmd, got.drive_cmd,
                       $sformatf("strobe exp %0b got %0b", want.send_strobe,
                                 got.send_strobe));
            end
          end
        end
      end

      // input transfer
      if (in_valid && in_ready) begin
        tick.axis_steer   = in_axis_steer;
        tick.axis_drive   = in_axis_drive;
        tick.estop_button = in_estop_button;
        tick.halt         = in_halt;
        cmd_q.push_back(map_tick(tick));
      end
    end
    n_fail    <= fail_cnt;
    n_pending <= cmd_q.size();
  end

endmodule

### verif/joystick_to_servo_command_tb.sv
`timescale 1ns / 100ps

module joystick_to_servo_command_tb
  import jts_pkg::*;
();

  localparam int TICKS_PER_PHASE = 200;
  localparam int DRAIN_CYCLES    = 10;

  // receiver behavior modes
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  typedef struct {
    logic [15:0] neutral;
    logic [15:0] sdz;
    logic [15:0] ddz;
    logic [15:0] gain;
    logic [15:0] scale;
    logic [15:0] hold;
    logic [15:0] div;
  } reg_set_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [15:0]    in_axis_steer = '0;
  logic signed [15:0]    in_axis_drive = '0;
  logic                  in_estop_button = 1'b0;
  logic                  in_halt = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [11:0]           out_steer_cmd;
  logic [11:0]           out_drive_cmd;
  logic                  out_send_strobe;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int       n_fail;
  int       n_pending;
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  logic [14:0] cur_sdz = RST_STEER_DEADZONE;
  logic [14:0] cur_ddz = RST_DRIVE_DEADZONE;
  reg_set_t settings[8];

  initial begin
    forever #6 clk = ~clk;
  end

  joystick_to_servo_command i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_axis_steer   (in_axis_steer),
    .in_axis_drive   (in_axis_drive),
    .in_estop_button (in_estop_button),
    .in_halt         (in_halt),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_steer_cmd   (out_steer_cmd),
    .out_drive_cmd   (out_drive_cmd),
    .out_send_strobe (out_send_strobe),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  jts_tick_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_axis_steer   (in_axis_steer),
    .in_axis_drive   (in_axis_drive),
    .in_estop_button (in_estop_button),
    .in_halt         (in_halt),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_steer_cmd   (out_steer_cmd),
    .out_drive_cmd   (out_drive_cmd),
    .out_send_strobe (out_send_strobe),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .n_fail          (n_fail),
    .n_pending       (n_pending)
  );

  // Receiver: switches between stall patterns every so often
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 150);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:     out_ready <= 1'b1;
      RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
      RX_PERIODIC: out_ready <= (rx_left[3:0] == 4'd0);
      default:     out_ready <= 1'b1;
    endcase
  end

  // Present one tick and hold it until the transfer; bursts with gaps between
  task automatic drive_tick(input logic [15:0] steer, input logic [15:0] drive,
                            input logic press, input logic stop);
    int gap;
    in_axis_steer   <= steer;
    in_axis_drive   <= drive;
    in_estop_button <= press;
    in_halt         <= stop;
    in_valid        <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop sending and wait until every predicted result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_settings(input reg_set_t s);
    write_reg(CFG_NEUTRAL_PULSE, s.neutral);
    write_reg(CFG_STEER_DEADZONE, s.sdz);
    write_reg(CFG_DRIVE_DEADZONE, s.ddz);
    write_reg(CFG_STEER_GAIN, s.gain);
    write_reg(CFG_DRIVE_SCALE, s.scale);
    write_reg(CFG_ESTOP_HOLD_TICKS, s.hold);
    write_reg(CFG_SEND_DIVIDER, s.div);
    cfg_we  <= 1'b0;
    cur_sdz = s.sdz[14:0];
    cur_ddz = s.ddz[14:0];
  endtask

  // Axis value biased toward the extremes and the deadzone edges
  function automatic logic [15:0] pick_axis(input logic [14:0] dz);
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0: v = 16'h8000;
      1: v = 16'h7fff;
      2: v = {1'b0, dz};
      3: v = {1'b0, dz} + 16'd1;
      4: v = 16'($urandom_range(0, 255));
      default: v = 16'($urandom_range(0, 65535));
    endcase
    if (v != 16'h8000 && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic random_ticks(input int n);
    for (int k = 0; k < n; k++) begin
      drive_tick(pick_axis(cur_sdz), pick_axis(cur_ddz),
                 ($urandom_range(0, 39) == 0), ($urandom_range(0, 24) == 0));
    end
  endtask

  initial begin
    reg_set_t rs;
    settings[0] = '{16'd0, 16'd0, 16'd0, 16'd2047, 16'd65535, 16'd3, 16'd1};
    settings[1] = '{16'd4095, 16'd32767, 16'd32767, 16'd0, 16'd0, 16'd0, 16'd255};
    settings[2] = '{16'd2048, 16'd100, 16'd200, 16'd1024, 16'd300, 16'd5, 16'd0};
    settings[3] = '{16'd1500, 16'd6554, 16'd9830, 16'd500, 16'd36571, 16'd100, 16'd10};
    settings[4] = '{16'd4095, 16'd1, 16'd1, 16'd2047, 16'd65535, 16'd65535, 16'd7};
    for (int p = 5; p < 8; p++) begin
      settings[p] = '{16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 12)),
                      16'($urandom_range(0, 65535))};
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, axis extremes and deadzone edges
    drive_tick(16'sd0, 16'sd0, 1'b0, 1'b0);
    drive_tick(16'sd32767, 16'sd32767, 1'b0, 1'b0);
    drive_tick(-16'sd32768, -16'sd32768, 1'b0, 1'b0);
    drive_tick(16'sd6554, 16'sd9830, 1'b0, 1'b0);
    drive_tick(16'sd6555, 16'sd9831, 1'b0, 1'b0);
    drive_tick(-16'sd6554, -16'sd9830, 1'b0, 1'b0);
    drive_tick(-16'sd6555, -16'sd9831, 1'b0, 1'b0);
    drive_tick(16'sd1, -16'sd1, 1'b0, 1'b0);
    // halt ignores the button and leaves the phase alone
    drive_tick(16'sd32767, -16'sd32768, 1'b1, 1'b1);
    drive_tick(-16'sd20000, 16'sd20000, 1'b0, 1'b1);
    drive_tick(16'sd20000, -16'sd20000, 1'b0, 1'b0);
    wait_drained();

    // Directed: short hold and divider
    rs = '{16'd1500, 16'd6554, 16'd9830, 16'd500, 16'd36571, 16'd2, 16'd3};
    load_settings(rs);
    drive_tick(16'sd30000, -16'sd30000, 1'b1, 1'b0);
    drive_tick(16'sd30000, -16'sd30000, 1'b0, 1'b0);
    drive_tick(16'sd30000, -16'sd30000, 1'b0, 1'b1);
    drive_tick(16'sd30000, -16'sd30000, 1'b0, 1'b0);
    drive_tick(16'sd30000, -16'sd30000, 1'b0, 1'b0);
    drive_tick(-16'sd30000, 16'sd30000, 1'b1, 1'b0);
    drive_tick(-16'sd30000, 16'sd30000, 1'b1, 1'b0);
    drive_tick(-16'sd30000, 16'sd30000, 1'b0, 1'b0);
    drive_tick(-16'sd30000, 16'sd30000, 1'b0, 1'b0);
    drive_tick(-16'sd30000, 16'sd30000, 1'b0, 1'b0);
    wait_drained();

    // Random phases; a large divider followed by a small one resets the phase
    for (int p = 0; p < 8; p++) begin
      load_settings(settings[p]);
      random_ticks(TICKS_PER_PHASE);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0 && n_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6ms;
    $display("simulation failed");
    $finish;
  end

endmodule

### joystick_to_servo_command.f
hw/rtl/jts_pkg.sv
hw/rtl/jts_map.sv
hw/rtl/joystick_to_servo_command.sv
hw/rtl/jts_checker.sv
verif/jts_tick_checker.sv
verif/joystick_to_servo_command_tb.sv
